>>> hdl/fcspm_pkg.sv
// Shared types, widths and constant tables for the four-channel stereo pan mixer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.

package fcspm_pkg;

    // Channel and field widths
    localparam int CHANNELS     = 4;
    localparam int PRESENT_BITS = CHANNELS - 1;
    localparam int SAMPLE_BITS  = 16;
    localparam int GAIN_BITS    = 16;
    localparam int MASTER_BITS  = 16;
    localparam int WEIGHT_BITS  = 7;
    localparam int VOL_BITS     = 7;
    localparam int PAN_BITS     = 8;
    localparam int OUT_BITS     = 16;

    // Setting ranges and pan curve knees
    localparam int VOL_MAX        = 100;
    localparam int PAN_MAX        = 200;
    localparam int WEIGHT_FULL    = 100;
    localparam int PAN_LEFT_KNEE  = 50;
    localparam int PAN_RIGHT_KNEE = 150;

    // Configuration register map
    localparam int CFG_INDEX_BITS  = 8;
    localparam int CFG_DATA_BITS   = 8;
    localparam int REG_VOLUME_BASE = 0;
    localparam int REG_PAN_BASE    = CHANNELS;

    // Datapath widths
    localparam int TERM_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int WTERM_BITS  = TERM_BITS + WEIGHT_BITS + 1;
    localparam int SUM_BITS    = WTERM_BITS + $clog2(CHANNELS);
    localparam int SPLIT_LO    = 22;
    localparam int SPLIT_HI    = SUM_BITS - SPLIT_LO;
    localparam int PHI_BITS    = SPLIT_HI + MASTER_BITS + 1;
    localparam int PLO_BITS    = SPLIT_LO + MASTER_BITS;
    localparam int PROD_BITS   = PHI_BITS + SPLIT_LO + 1;
    localparam int SCALE_SHIFT = SAMPLE_BITS + 14;
    localparam int Y_BITS      = PROD_BITS - SCALE_SHIFT;

    // Output saturation and divide-by-100 via reciprocal
    localparam int OUT_MAX     = 32767;
    localparam int Y_POS_LIM   = WEIGHT_FULL * (OUT_MAX + 1);
    localparam int Y_NEG_LIM   = -(WEIGHT_FULL * OUT_MAX);
    localparam int U_BITS      = 23;
    localparam int RECIP_SHIFT = U_BITS + 7;
    localparam int RECIP_BITS  = 24;
    localparam int RECIP       = (2 ** RECIP_SHIFT + WEIGHT_FULL - 1) / WEIGHT_FULL;
    localparam int QP_BITS     = U_BITS + RECIP_BITS;

    // Volume curve: gain = (v/100)^1.4 * 0.8192 in Q0.16, round half up.
    // Found exactly with integers: b = floor(2*gain) is the largest b with
    // b^5 * 5^34 <= v^7 * 2^116, and the gain is (b+1)/2.
    localparam int ROOT_BITS       = 200;
    localparam int GAIN_SEARCH_TOP = 131071;

    typedef logic [GAIN_BITS-1:0] gain_table_t [0:VOL_MAX];

    function automatic logic [GAIN_BITS-1:0] exact_gain(input int vol);
        logic [ROOT_BITS-1:0] target;
        logic [ROOT_BITS-1:0] trial;
        logic [ROOT_BITS-1:0] five_pow;
        int                   lo;
        int                   hi;
        int                   mid;
        target = ROOT_BITS'(1);
        for (int k = 0; k < 7; k++) target = target * ROOT_BITS'(vol);
        target = target << 116;
        five_pow = ROOT_BITS'(1);
        for (int k = 0; k < 34; k++) five_pow = five_pow * ROOT_BITS'(5);
        lo = 0;
        hi = GAIN_SEARCH_TOP;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            trial = five_pow;
            for (int k = 0; k < 5; k++) trial = trial * ROOT_BITS'(mid);
            if (trial <= target) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return GAIN_BITS'((lo + 1) >> 1);
    endfunction

    function automatic gain_table_t build_gain_table();
        gain_table_t tbl;
        for (int v = 0; v <= VOL_MAX; v++) begin
            tbl[v] = exact_gain(v);
        end
        return tbl;
    endfunction

    localparam gain_table_t GAIN_TABLE = build_gain_table();

    // Pan setting to right weight in hundredths
    function automatic logic [WEIGHT_BITS-1:0] right_weight(input logic [PAN_BITS-1:0] pan);
        logic [WEIGHT_BITS-1:0] w;
        if (pan <= PAN_BITS'(PAN_LEFT_KNEE)) begin
            w = WEIGHT_BITS'(PAN_LEFT_KNEE + int'(pan));
        end else if (pan <= PAN_BITS'(PAN_RIGHT_KNEE)) begin
            w = WEIGHT_BITS'(PAN_RIGHT_KNEE - int'(pan));
        end else begin
            w = WEIGHT_BITS'(int'(pan) - PAN_RIGHT_KNEE);
        end
        return w;
    endfunction

    // Input item
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_ch0;
        logic signed [SAMPLE_BITS-1:0] sample_ch1;
        logic signed [SAMPLE_BITS-1:0] sample_ch2;
        logic signed [SAMPLE_BITS-1:0] sample_ch3;
        logic [PRESENT_BITS-1:0]       channel_present;
        logic [MASTER_BITS-1:0]        master_gain_left;
        logic [MASTER_BITS-1:0]        master_gain_right;
        logic                          batch_end;
    } in_t;

    // Result item
    typedef struct packed {
        logic signed [OUT_BITS-1:0] left_out;
        logic signed [OUT_BITS-1:0] right_out;
        logic                       clipped;
        logic                       batch_end_out;
    } out_t;

    // Per-channel coefficients from the register file
    typedef struct packed {
        logic [CHANNELS-1:0][GAIN_BITS-1:0]   gain;
        logic [CHANNELS-1:0][WEIGHT_BITS-1:0] w_right;
        logic [CHANNELS-1:0][WEIGHT_BITS-1:0] w_left;
    } coef_t;

    // Side sums handed from the channel pipe to the scaler
    typedef struct packed {
        logic signed [SUM_BITS-1:0] sum_left;
        logic signed [SUM_BITS-1:0] sum_right;
        logic [MASTER_BITS-1:0]     master_left;
        logic [MASTER_BITS-1:0]     master_right;
        logic                       batch_end;
    } sum_t;

endpackage

>>> hdl/fcspm_cfg.sv
// Configuration register file: volume and pan settings turned into gains and weights.
// Depends on fcspm_pkg (gain table, pan curve, coef_t).

module fcspm_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fcspm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fcspm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output fcspm_pkg::coef_t                     coef
);

    localparam logic [fcspm_pkg::VOL_BITS-1:0] VOL_TOP =
        fcspm_pkg::VOL_BITS'(fcspm_pkg::VOL_MAX);
    localparam logic [fcspm_pkg::PAN_BITS-1:0] PAN_TOP =
        fcspm_pkg::PAN_BITS'(fcspm_pkg::PAN_MAX);
    localparam logic [fcspm_pkg::WEIGHT_BITS-1:0] W_FULL =
        fcspm_pkg::WEIGHT_BITS'(fcspm_pkg::WEIGHT_FULL);

    logic [fcspm_pkg::VOL_BITS-1:0]    vol_clamped;
    logic [fcspm_pkg::PAN_BITS-1:0]    pan_clamped;
    logic [fcspm_pkg::GAIN_BITS-1:0]   gain_wr;
    logic [fcspm_pkg::WEIGHT_BITS-1:0] right_wr;
    fcspm_pkg::coef_t                  coef_reg;
    fcspm_pkg::coef_t                  coef_next;
    logic                              weights_ok;

    // Writes are taken every cycle
    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    // Clamp and convert the write data
    always_comb begin
        vol_clamped = cfg_data[fcspm_pkg::VOL_BITS-1:0];
        if (vol_clamped > VOL_TOP) begin
            vol_clamped = VOL_TOP;
        end
        pan_clamped = cfg_data[fcspm_pkg::PAN_BITS-1:0];
        if (pan_clamped > PAN_TOP) begin
            pan_clamped = PAN_TOP;
        end
        gain_wr  = fcspm_pkg::GAIN_TABLE[vol_clamped];
        right_wr = fcspm_pkg::right_weight(pan_clamped);
    end

    // Register decode; unknown indexes are dropped
    always_comb begin
        coef_next = coef_reg;
        for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
            if (cfg_valid && cfg_index ==
                fcspm_pkg::CFG_INDEX_BITS'(fcspm_pkg::REG_VOLUME_BASE + c)) begin
                coef_next.gain[c] = gain_wr;
            end
            if (cfg_valid && cfg_index ==
                fcspm_pkg::CFG_INDEX_BITS'(fcspm_pkg::REG_PAN_BASE + c)) begin
                coef_next.w_right[c] = right_wr;
                coef_next.w_left[c]  = W_FULL - right_wr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
                coef_reg.gain[c]    <= fcspm_pkg::GAIN_TABLE[fcspm_pkg::VOL_MAX];
                coef_reg.w_right[c] <= fcspm_pkg::right_weight('0);
                coef_reg.w_left[c]  <= W_FULL - fcspm_pkg::right_weight('0);
            end
        end else begin
            coef_reg <= coef_next;
        end
    end

    // Left and right weights always split one hundred
    always_comb begin
        weights_ok = 1'b1;
        for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
            if (coef_reg.w_right[c] > W_FULL ||
                coef_reg.w_right[c] + coef_reg.w_left[c] != W_FULL) begin
                weights_ok = 1'b0;
            end
        end
    end

    a_weights_split: assert property (@(posedge aclk) disable iff (!aresetn)
        weights_ok)
        else $error("pan weights do not sum to full scale");

    a_full_volume_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_index ==
            fcspm_pkg::CFG_INDEX_BITS'(fcspm_pkg::REG_VOLUME_BASE) &&
            cfg_data[fcspm_pkg::VOL_BITS-1:0] >= VOL_TOP
        |=> coef_reg.gain[0] == fcspm_pkg::GAIN_TABLE[fcspm_pkg::VOL_MAX])
        else $error("full volume write did not load the top gain");

endmodule

>>> hdl/fcspm_chan.sv
// Channel pipe: presence masking, channel gain, pan weights and side sums (3 stages).
// Depends on fcspm_pkg (in_t, coef_t, sum_t, widths).

module fcspm_chan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fcspm_pkg::in_t    s_payload,
    input  fcspm_pkg::coef_t  coef,
    output logic              sum_valid,
    input  logic              sum_ready,
    output fcspm_pkg::sum_t   sum_data
);

    logic signed [fcspm_pkg::SAMPLE_BITS-1:0] raw    [fcspm_pkg::CHANNELS];
    logic signed [fcspm_pkg::SAMPLE_BITS-1:0] sample [fcspm_pkg::CHANNELS];

    // Stage A: sample times channel gain
    logic                                    a_valid_reg;
    logic                                    a_en;
    logic signed [fcspm_pkg::TERM_BITS-1:0]  term_reg  [fcspm_pkg::CHANNELS];
    logic signed [fcspm_pkg::TERM_BITS-1:0]  term_next [fcspm_pkg::CHANNELS];
    logic [fcspm_pkg::MASTER_BITS-1:0]       a_gl_reg, a_gr_reg;
    logic                                    a_be_reg;

    // Stage B: weighted terms per side
    logic                                    b_valid_reg;
    logic                                    b_en;
    logic signed [fcspm_pkg::WTERM_BITS-1:0] wr_reg  [fcspm_pkg::CHANNELS];
    logic signed [fcspm_pkg::WTERM_BITS-1:0] wl_reg  [fcspm_pkg::CHANNELS];
    logic signed [fcspm_pkg::WTERM_BITS-1:0] wr_next [fcspm_pkg::CHANNELS];
    logic signed [fcspm_pkg::WTERM_BITS-1:0] wl_next [fcspm_pkg::CHANNELS];
    logic [fcspm_pkg::MASTER_BITS-1:0]       b_gl_reg, b_gr_reg;
    logic                                    b_be_reg;

    // Stage C: side sums
    logic                                    c_valid_reg;
    logic                                    c_en;
    fcspm_pkg::sum_t                         sum_reg;
    fcspm_pkg::sum_t                         sum_next;

    // Stall chain: a stage loads when empty or when the next one moves
    assign c_en    = !c_valid_reg || sum_ready;
    assign b_en    = !b_valid_reg || c_en;
    assign a_en    = !a_valid_reg || b_en;
    assign s_ready = a_en;

    assign sum_valid = c_valid_reg;
    assign sum_data  = sum_reg;

    // Absent channels count as zero; channel zero always present
    always_comb begin
        raw[0] = s_payload.sample_ch0;
        raw[1] = s_payload.sample_ch1;
        raw[2] = s_payload.sample_ch2;
        raw[3] = s_payload.sample_ch3;
        sample[0] = raw[0];
        for (int c = 1; c < fcspm_pkg::CHANNELS; c++) begin
            sample[c] = s_payload.channel_present[c-1] ? raw[c] : '0;
        end
        for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
            term_next[c] = sample[c] * $signed({1'b0, coef.gain[c]});
        end
    end

    // Pan weights
    always_comb begin
        for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
            wr_next[c] = term_reg[c] * $signed({1'b0, coef.w_right[c]});
            wl_next[c] = term_reg[c] * $signed({1'b0, coef.w_left[c]});
        end
    end

    // Sum over channels
    always_comb begin
        sum_next.sum_left  = '0;
        sum_next.sum_right = '0;
        for (int c = 0; c < fcspm_pkg::CHANNELS; c++) begin
            sum_next.sum_left  = sum_next.sum_left  + fcspm_pkg::SUM_BITS'(wl_reg[c]);
            sum_next.sum_right = sum_next.sum_right + fcspm_pkg::SUM_BITS'(wr_reg[c]);
        end
        sum_next.master_left  = b_gl_reg;
        sum_next.master_right = b_gr_reg;
        sum_next.batch_end    = b_be_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_en) a_valid_reg <= s_valid;
            if (b_en) b_valid_reg <= a_valid_reg;
            if (c_en) c_valid_reg <= b_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (a_en) begin
            term_reg <= term_next;
            a_gl_reg <= s_payload.master_gain_left;
            a_gr_reg <= s_payload.master_gain_right;
            a_be_reg <= s_payload.batch_end;
        end
        if (b_en) begin
            wr_reg   <= wr_next;
            wl_reg   <= wl_next;
            b_gl_reg <= a_gl_reg;
            b_gr_reg <= a_gr_reg;
            b_be_reg <= a_be_reg;
        end
        if (c_en) begin
            sum_reg <= sum_next;
        end
    end

    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !sum_ready |=> c_valid_reg && $stable(sum_reg))
        else $error("stalled side sum was lost or changed");

endmodule

>>> hdl/fcspm_scale.sv
// Master scaler: sum times master gain, floor divide, saturate (4 stages incl. output).
// Depends on fcspm_pkg (sum_t, out_t, widths and reciprocal constants).

module fcspm_scale (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             sum_valid,
    output logic             sum_ready,
    input  fcspm_pkg::sum_t  sum_data,
    output logic             m_valid,
    input  logic             m_ready,
    output fcspm_pkg::out_t  m_payload
);

    localparam logic signed [fcspm_pkg::Y_BITS-1:0] Y_HI =
        fcspm_pkg::Y_BITS'(fcspm_pkg::Y_POS_LIM);
    localparam logic signed [fcspm_pkg::Y_BITS-1:0] Y_LO =
        fcspm_pkg::Y_BITS'(fcspm_pkg::Y_NEG_LIM);
    localparam logic [fcspm_pkg::RECIP_BITS-1:0] RECIP_K =
        fcspm_pkg::RECIP_BITS'(fcspm_pkg::RECIP);
    localparam logic signed [fcspm_pkg::OUT_BITS-1:0] OUT_HI =
        fcspm_pkg::OUT_BITS'(fcspm_pkg::OUT_MAX);
    localparam logic signed [fcspm_pkg::OUT_BITS-1:0] OUT_LO = -OUT_HI;
    localparam logic [fcspm_pkg::OUT_BITS-1:0] OUT_BIAS =
        fcspm_pkg::OUT_BITS'(fcspm_pkg::OUT_MAX + 1);
    localparam logic signed [fcspm_pkg::OUT_BITS-1:0] OUT_NEG_FULL =
        {1'b1, {(fcspm_pkg::OUT_BITS-1){1'b0}}};

    // Stage D: split partial products
    logic                                    d_valid_reg, d_en;
    logic signed [fcspm_pkg::PHI_BITS-1:0]   phi_l_reg, phi_r_reg;
    logic [fcspm_pkg::PLO_BITS-1:0]          plo_l_reg, plo_r_reg;
    logic                                    d_be_reg;

    // Stage E: floored product over 2^30
    logic                                    e_valid_reg, e_en;
    logic signed [fcspm_pkg::PROD_BITS-1:0]  prod_l, prod_r;
    logic signed [fcspm_pkg::Y_BITS-1:0]     y_l_reg, y_r_reg;
    logic                                    e_be_reg;

    // Stage F: range flags and reciprocal product
    logic                                    f_valid_reg, f_en;
    logic [fcspm_pkg::U_BITS-1:0]            u_l, u_r;
    logic [fcspm_pkg::QP_BITS-1:0]           qp_l_reg, qp_r_reg;
    logic                                    pos_l_reg, neg_l_reg, pos_r_reg, neg_r_reg;
    logic                                    f_be_reg;

    // Stage G: output register
    logic                                    g_en;
    logic                                    m_valid_reg;
    fcspm_pkg::out_t                         out_reg, out_next;

    assign g_en      = !m_valid_reg || m_ready;
    assign f_en      = !f_valid_reg || g_en;
    assign e_en      = !e_valid_reg || f_en;
    assign d_en      = !d_valid_reg || e_en;
    assign sum_ready = d_en;
    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    function automatic logic signed [fcspm_pkg::OUT_BITS-1:0] sat_side(
        input logic                          pos,
        input logic                          neg,
        input logic [fcspm_pkg::QP_BITS-1:0] qp
    );
        logic [fcspm_pkg::OUT_BITS-1:0] q;
        q = qp[fcspm_pkg::RECIP_SHIFT +: fcspm_pkg::OUT_BITS];
        if (pos) begin
            return OUT_HI;
        end else if (neg) begin
            return OUT_LO;
        end
        return $signed(q - OUT_BIAS);
    endfunction

    // Rebuild full product; arithmetic shift gives the floor
    always_comb begin
        prod_l = (fcspm_pkg::PROD_BITS'(phi_l_reg) <<< fcspm_pkg::SPLIT_LO)
               + $signed(fcspm_pkg::PROD_BITS'(plo_l_reg));
        prod_r = (fcspm_pkg::PROD_BITS'(phi_r_reg) <<< fcspm_pkg::SPLIT_LO)
               + $signed(fcspm_pkg::PROD_BITS'(plo_r_reg));
    end

    // Bias into an unsigned range for the divide by one hundred
    assign u_l = fcspm_pkg::U_BITS'(y_l_reg + Y_HI);
    assign u_r = fcspm_pkg::U_BITS'(y_r_reg + Y_HI);

    always_comb begin
        out_next.left_out      = sat_side(pos_l_reg, neg_l_reg, qp_l_reg);
        out_next.right_out     = sat_side(pos_r_reg, neg_r_reg, qp_r_reg);
        out_next.clipped       = pos_l_reg | neg_l_reg | pos_r_reg | neg_r_reg;
        out_next.batch_end_out = f_be_reg;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (d_en) d_valid_reg <= sum_valid;
            if (e_en) e_valid_reg <= d_valid_reg;
            if (f_en) f_valid_reg <= e_valid_reg;
            if (g_en) m_valid_reg <= f_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (d_en) begin
            phi_l_reg <= $signed(sum_data.sum_left[fcspm_pkg::SUM_BITS-1:fcspm_pkg::SPLIT_LO])
                       * $signed({1'b0, sum_data.master_left});
            phi_r_reg <= $signed(sum_data.sum_right[fcspm_pkg::SUM_BITS-1:fcspm_pkg::SPLIT_LO])
                       * $signed({1'b0, sum_data.master_right});
            plo_l_reg <= sum_data.sum_left[fcspm_pkg::SPLIT_LO-1:0] * sum_data.master_left;
            plo_r_reg <= sum_data.sum_right[fcspm_pkg::SPLIT_LO-1:0] * sum_data.master_right;
            d_be_reg  <= sum_data.batch_end;
        end
        if (e_en) begin
            y_l_reg  <= $signed(prod_l[fcspm_pkg::PROD_BITS-1:fcspm_pkg::SCALE_SHIFT]);
            y_r_reg  <= $signed(prod_r[fcspm_pkg::PROD_BITS-1:fcspm_pkg::SCALE_SHIFT]);
            e_be_reg <= d_be_reg;
        end
        if (f_en) begin
            pos_l_reg <= y_l_reg >= Y_HI;
            neg_l_reg <= y_l_reg < Y_LO;
            pos_r_reg <= y_r_reg >= Y_HI;
            neg_r_reg <= y_r_reg < Y_LO;
            qp_l_reg  <= u_l * RECIP_K;
            qp_r_reg  <= u_r * RECIP_K;
            f_be_reg  <= e_be_reg;
        end
        if (g_en) begin
            out_reg <= out_next;
        end
    end

    a_clip_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.clipped |->
            m_payload.left_out == OUT_HI || m_payload.left_out == OUT_LO ||
            m_payload.right_out == OUT_HI || m_payload.right_out == OUT_LO)
        else $error("clip flag set without a saturated side");

    a_no_full_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload.left_out != OUT_NEG_FULL &&
                    m_payload.right_out != OUT_NEG_FULL)
        else $error("output reached the full negative code");

    a_stage_f_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        f_valid_reg && !g_en |=> f_valid_reg && $stable(qp_l_reg) && $stable(qp_r_reg))
        else $error("stalled quotient stage changed");

endmodule

>>> hdl/four_channel_stereo_pan_mixer_top.sv
// Each item passes registered stages A, B, C (fcspm_chan) and D, E, F, G (fcspm_scale).
// Throughput: one item per cycle unless m_ready stalls; the pipeline holds up to
// seven items, each stage with its own valid bit, and a stall backs up stage by stage.
// Timing is set by the 21x17 partial-product multipliers and the 23x24 reciprocal.
// Reset (aresetn low, synchronous): pipeline empties, volumes return to 100 and
// pans to 0. Configuration writes are taken every cycle.
// Depends on fcspm_pkg, fcspm_cfg, fcspm_chan and fcspm_scale.

module four_channel_stereo_pan_mixer_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  fcspm_pkg::in_t                       s_payload,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output fcspm_pkg::out_t                      m_payload,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fcspm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [fcspm_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    fcspm_pkg::coef_t coef;
    logic             sum_valid;
    logic             sum_ready;
    fcspm_pkg::sum_t  sum_data;

    // Settings to gains and weights
    fcspm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // Per-channel gain, pan and summing
    fcspm_chan u_chan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .coef      (coef),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_data  (sum_data)
    );

    // Master gain, floor and saturation
    fcspm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_data  (sum_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule
